[rtl/core/distributed_mutex_node_core_macros.svh]
// assertion macros shared by the distributed mutex node rtl
`ifndef DISTRIBUTED_MUTEX_NODE_CORE_MACROS_SVH
`define DISTRIBUTED_MUTEX_NODE_CORE_MACROS_SVH

// property that must hold at every clock edge out of reset
`define DMN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define DMN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DMN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/dmn_pkg.sv]
// types, constants and codes of the distributed mutex node
`default_nettype none
package dmn_pkg;

  localparam int MAX_NODES = 16;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int CLOCK_W   = 16;
  localparam int CFG_W     = 5;

  localparam logic [CLOCK_W-1:0] CLK_MAX = '1;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_MSG   = 2'd1;
  localparam logic [1:0] CMD_LEAVE = 2'd2;

  localparam logic MSG_REQ  = 1'b0;
  localparam logic MSG_RESP = 1'b1;

  localparam logic CFG_NODE_INDEX = 1'b0;
  localparam logic CFG_NODE_COUNT = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_CRIT = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    K_REQ   = 3'd0,
    K_RESP  = 3'd1,
    K_ENTER = 3'd2,
    K_NONE  = 3'd3,
    K_REJ   = 3'd4
  } out_kind_e;

  typedef enum logic [1:0] {
    ST_READY = 2'd0,
    ST_EXEC  = 2'd1,
    ST_SCAN  = 2'd2
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic scan;
  } dmn_cmd_t;

  typedef struct packed {
    logic out_free;
    logic multi;
    logic scan_last;
  } dmn_stat_t;

endpackage
`default_nettype wire

[rtl/core/dmn_ctrl.sv]
// control state machine of the distributed mutex node
`default_nettype none
module dmn_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire dmn_pkg::dmn_stat_t stat_i,
  output dmn_pkg::dmn_cmd_t      cmd_o
);
  import dmn_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_READY;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_READY: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat_i.out_free) state_d = stat_i.multi ? ST_SCAN : ST_READY;
      end
      ST_SCAN: begin
        if (stat_i.scan_last) state_d = ST_READY;
      end
      default: state_d = ST_READY;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_READY: begin
        in_stall_o  = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.exec = stat_i.out_free;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/dmn_dpath.sv]
// protocol state, config registers, peer scan and result register
`default_nettype none
`include "distributed_mutex_node_core_macros.svh"
module dmn_dpath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_index_i,
  input  wire logic [dmn_pkg::CFG_W-1:0]   cfg_data_i,
  input  wire logic [1:0]                  command_i,
  input  wire logic [dmn_pkg::NODE_W-1:0]  sender_i,
  input  wire logic                        msg_kind_i,
  input  wire logic [dmn_pkg::CLOCK_W-1:0] msg_clock_i,
  input  wire logic                        out_stall_i,
  output logic                             out_valid_o,
  output logic [2:0]                       out_kind_o,
  output logic [dmn_pkg::NODE_W-1:0]       peer_o,
  output logic [dmn_pkg::CLOCK_W-1:0]      out_clock_o,
  output logic                             last_o,
  input  wire dmn_pkg::dmn_cmd_t           cmd_i,
  output dmn_pkg::dmn_stat_t               stat_o
);
  import dmn_pkg::*;

  logic [NODE_W-1:0]    node_index_q;
  logic [CNT_W-1:0]     node_count_q;
  phase_e               phase_q, phase_d;
  logic [CLOCK_W-1:0]   clock_q, clock_d;
  logic [MAX_NODES-1:0] deferred_q, deferred_d;
  logic [CNT_W-1:0]     reply_q, reply_d;
  logic [MAX_NODES-1:0] pend_q, pend_d;
  logic [NODE_W-1:0]    idx_q, idx_d;

  logic [1:0]           cmd_q;
  logic [NODE_W-1:0]    sender_q;
  logic                 kind_q;
  logic [CLOCK_W-1:0]   mclk_q;

  logic                 out_valid_q, out_valid_d;
  out_kind_e            out_kind_q, out_kind_d;
  logic [NODE_W-1:0]    peer_q, peer_d;
  logic [CLOCK_W-1:0]   oclk_q, oclk_d;
  logic                 last_q, last_d;
  logic                 out_load;

  logic [CNT_W-1:0]     eff;
  logic [CNT_W-1:0]     needed;
  logic [MAX_NODES-1:0] peer_mask;
  logic [MAX_NODES-1:0] leave_mask;
  logic [MAX_NODES-1:0] pend_rest;
  logic [CLOCK_W-1:0]   clk_max;
  logic [CLOCK_W-1:0]   merged;
  logic [CNT_W-1:0]     reply_inc;
  logic                 local_wins;
  logic                 do_start, do_msg, do_leave;
  logic                 out_free;
  logic                 scan_emit;

  // effective node count, peer set and number of responses to collect
  always_comb begin
    eff = (node_count_q > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_q;
    for (int i = 0; i < MAX_NODES; i++) begin
      peer_mask[i] = (CNT_W'(i) < eff) && (NODE_W'(i) != node_index_q);
    end
    needed = eff - ((CNT_W'(node_index_q) < eff) ? CNT_W'(1) : CNT_W'(0));
  end

  assign leave_mask = peer_mask & deferred_q;
  assign clk_max    = (clock_q > mclk_q) ? clock_q : mclk_q;
  assign merged     = (clk_max == CLK_MAX) ? clk_max : clk_max + CLOCK_W'(1);
  assign reply_inc  = reply_q + CNT_W'(1);
  assign local_wins = (clock_q > mclk_q) ||
                      ((clock_q == mclk_q) && (node_index_q > sender_q));

  assign do_start = (cmd_q == CMD_START) && (phase_q == PH_IDLE);
  assign do_msg   = (cmd_q == CMD_MSG) && (phase_q == PH_WAIT) && peer_mask[sender_q];
  assign do_leave = (cmd_q == CMD_LEAVE) && (phase_q == PH_CRIT);

  assign out_free  = !out_valid_q || !out_stall_i;
  assign pend_rest = pend_q & ~(MAX_NODES'(1) << idx_q);
  assign scan_emit = cmd_i.scan && pend_q[idx_q] && out_free;

  assign stat_o.out_free  = out_free;
  assign stat_o.multi     = (do_start && (peer_mask != '0)) ||
                            (do_leave && (leave_mask != '0));
  assign stat_o.scan_last = scan_emit && (pend_rest == '0);

  always_comb begin
    phase_d    = phase_q;
    clock_d    = clock_q;
    deferred_d = deferred_q;
    reply_d    = reply_q;
    pend_d     = pend_q;
    idx_d      = idx_q;
    out_load   = 1'b0;
    out_kind_d = K_NONE;
    peer_d     = '0;
    oclk_d     = '0;
    last_d     = 1'b1;

    if (cmd_i.exec) begin
      idx_d = '0;
      priority if (do_start) begin
        deferred_d = '0;
        reply_d    = '0;
        pend_d     = peer_mask;
        if (peer_mask == '0) begin
          // lone node goes straight in
          phase_d    = PH_CRIT;
          out_load   = 1'b1;
          out_kind_d = K_ENTER;
          oclk_d     = clock_q;
        end else begin
          phase_d = PH_WAIT;
        end
      end else if (do_msg) begin
        out_load = 1'b1;
        if (kind_q == MSG_REQ) begin
          if (local_wins) begin
            out_kind_d = K_RESP;
            peer_d     = sender_q;
            oclk_d     = clock_q;
          end else begin
            deferred_d[sender_q] = 1'b1;
            clock_d              = merged;
          end
        end else begin
          clock_d = merged;
          reply_d = reply_inc;
          if (reply_inc >= needed) begin
            phase_d    = PH_CRIT;
            out_kind_d = K_ENTER;
            oclk_d     = merged;
          end
        end
      end else if (do_leave) begin
        deferred_d = '0;
        reply_d    = '0;
        phase_d    = PH_IDLE;
        pend_d     = leave_mask;
        if (leave_mask == '0) begin
          out_load = 1'b1;
        end
      end else begin
        out_load   = 1'b1;
        out_kind_d = K_REJ;
      end
    end else if (cmd_i.scan) begin
      if (scan_emit) begin
        out_load   = 1'b1;
        out_kind_d = (cmd_q == CMD_START) ? K_REQ : K_RESP;
        peer_d     = idx_q;
        oclk_d     = clock_q;
        last_d     = (pend_rest == '0);
        pend_d     = pend_rest;
      end
      if (!pend_q[idx_q] || out_free) idx_d = idx_q + NODE_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load)          out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_index_q <= '0;
      node_count_q <= CNT_W'(2);
      phase_q      <= PH_IDLE;
      clock_q      <= '0;
      deferred_q   <= '0;
      reply_q      <= '0;
      pend_q       <= '0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_NODE_INDEX: node_index_q <= cfg_data_i[NODE_W-1:0];
          CFG_NODE_COUNT: node_count_q <= cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      phase_q     <= phase_d;
      clock_q     <= clock_d;
      deferred_q  <= deferred_d;
      reply_q     <= reply_d;
      pend_q      <= pend_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q    <= command_i;
      sender_q <= sender_i;
      kind_q   <= msg_kind_i;
      mclk_q   <= msg_clock_i;
    end
    if (out_load) begin
      out_kind_q <= out_kind_d;
      peer_q     <= peer_d;
      oclk_q     <= oclk_d;
      last_q     <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign peer_o      = peer_q;
  assign out_clock_o = oclk_q;
  assign last_o      = last_q;

  // idle node holds no deferred peers and no counted responses
  `DMN_ASSERT_IMP(a_idle_clean, phase_q == PH_IDLE, (reply_q == '0) && (deferred_q == '0), "idle node holds stale protocol state")

endmodule
`default_nettype wire

[rtl/core/distributed_mutex_node_core.sv]
// top level of one distributed mutual exclusion node
// sequence: an item is captured in the ready state and decided in the exec state; a single result is
//   registered at the end of exec when the result register is free, later while a stall holds it
// broadcasts: a start or leave with peers to send to then walks the node slots from 0 up to the last
//   one that sends, one per cycle unless a stall holds a sending slot; no new item is taken meanwhile
// reset: asynchronous active low; idle phase, clock and deferred set cleared, no sweep
`default_nettype none
`include "distributed_mutex_node_core_macros.svh"
module distributed_mutex_node_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration writes
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_index_i,
  input  wire logic [dmn_pkg::CFG_W-1:0]   cfg_data_i,
  // input items
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [1:0]                  command_i,
  input  wire logic [dmn_pkg::NODE_W-1:0]  sender_i,
  input  wire logic                        msg_kind_i,
  input  wire logic [dmn_pkg::CLOCK_W-1:0] msg_clock_i,
  // result items
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [2:0]                       out_kind_o,
  output logic [dmn_pkg::NODE_W-1:0]       peer_o,
  output logic [dmn_pkg::CLOCK_W-1:0]      out_clock_o,
  output logic                             last_o
);
  import dmn_pkg::*;

  dmn_cmd_t  cmd;
  dmn_stat_t stat;

  // sequencer: ready, decide, then walk the peer slots for broadcasts
  dmn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // protocol state, lamport clock, deferred set and the result register
  dmn_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .command_i   (command_i),
    .sender_i    (sender_i),
    .msg_kind_i  (msg_kind_i),
    .msg_clock_i (msg_clock_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_kind_o  (out_kind_o),
    .peer_o      (peer_o),
    .out_clock_o (out_clock_o),
    .last_o      (last_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

  // an accepted item keeps the node busy for at least the decide cycle
  `DMN_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "node took two items back to back")
  // a broadcast still in progress must hold off new items
  `DMN_ASSERT_IMP(a_partial_busy, out_valid_o && !last_o, in_stall_o, "node ready while a broadcast is unfinished")
  // a pending non-final result comes from a send, never from enter, nothing or reject
  `DMN_ASSERT(a_partial_is_send, !(out_valid_o && !last_o) || out_kind_o == K_REQ || out_kind_o == K_RESP, "non-final result is not a send")

endmodule
`default_nettype wire
